// ===== rtl/sor_stencil_3d_defines.svh =====
// ----------------------------------------------------------------------------
// SOR stencil assertion macros
// Shared property wrappers for the checker of the SOR stencil block.
// ----------------------------------------------------------------------------
`ifndef SOR_STENCIL_3D_DEFINES_SVH
`define SOR_STENCIL_3D_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SOR3D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SOR3D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sor3d_pkg.sv =====
// ----------------------------------------------------------------------------
// SOR stencil package
// Grid geometry, command codes and the queue entry shared by the SOR modules.
// ----------------------------------------------------------------------------
package sor3d_pkg;

  // Inner grid size; the grid adds one halo point on every side.
  localparam int X_INNER = 14;
  localparam int Y_INNER = 14;
  localparam int Z_INNER = 14;

  localparam int COORD_W    = 4;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3 * COORD_W;
  localparam int GRID_DEPTH = 1 << ADDR_W;
  localparam int RELAX_W    = 15;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RELAX_W-1:0] RELAX_RESET = 15'd16384;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COPY    = 2'd1,
    OP_STENCIL = 2'd2,
    OP_SKIP    = 2'd3
  } sor3d_op_t;

  // For a copy, x already holds the x coordinate of the point to copy from.
  typedef struct packed {
    sor3d_op_t           op;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [DATA_W-1:0]   old_value;
    logic [DATA_W-1:0]   source;
  } sor3d_entry_t;

endpackage

// ===== rtl/sor3d_ram.sv =====
// ----------------------------------------------------------------------------
// SOR generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sor3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sor3d_front.sv =====
// ----------------------------------------------------------------------------
// SOR front end
// Accepts requests and sorts them into load, copy, stencil or skip entries.
// ----------------------------------------------------------------------------
module sor3d_front import sor3d_pkg::*; (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [COORD_W-1:0]        in_x_index,
  input  logic [COORD_W-1:0]        in_y_index,
  input  logic [COORD_W-1:0]        in_z_index,
  input  logic signed [DATA_W-1:0]  in_old_value_in,
  input  logic signed [DATA_W-1:0]  in_source_in,
  input  logic                      q_full,
  output logic                      q_push,
  output sor3d_entry_t              q_entry
);

  localparam logic [COORD_W-1:0] X_WRAP = COORD_W'(X_INNER);

  int xi, yi, zi;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    xi = int'(in_x_index);
    yi = int'(in_y_index);
    zi = int'(in_z_index);

    q_entry.x         = in_x_index;
    q_entry.y         = in_y_index;
    q_entry.z         = in_z_index;
    q_entry.old_value = in_old_value_in;
    q_entry.source    = in_source_in;
    q_entry.op        = OP_SKIP;

    // The halo rules are tried in order; the first match wins.
    priority if (in_command == CMD_LOAD) begin
      q_entry.op = OP_LOAD;
    end else if (xi == X_INNER + 1) begin
      q_entry.op = OP_COPY;
      q_entry.x  = COORD_W'(1);
    end else if (xi == 0) begin
      q_entry.op = OP_COPY;
      q_entry.x  = X_WRAP;
    end else if (yi == Y_INNER + 1) begin
      q_entry.op = OP_COPY;
      q_entry.x  = in_x_index - COORD_W'(1);
    end else if (yi == 0) begin
      q_entry.op = OP_COPY;
    end else if (xi <= X_INNER && yi <= Y_INNER && zi >= 1 && zi <= Z_INNER) begin
      q_entry.op = OP_STENCIL;
    end else begin
      q_entry.op = OP_SKIP;
    end
  end

endmodule

// ===== rtl/sor3d_queue.sv =====
// ----------------------------------------------------------------------------
// SOR request queue
// Short FIFO of classified entries between the front and the back end.
// ----------------------------------------------------------------------------
module sor3d_queue import sor3d_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  sor3d_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output sor3d_entry_t head_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sor3d_entry_t     entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/sor3d_back.sv =====
// ----------------------------------------------------------------------------
// SOR back end
// Owns the grid memories, runs loads, copies and the relaxed stencil, and
// holds the result register.
// ----------------------------------------------------------------------------
module sor3d_back import sor3d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [RELAX_W-1:0]        relax_factor,
  input  logic                      q_valid,
  input  sor3d_entry_t              q_entry,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_new_value,
  output logic                      out_written,
  output logic                      out_saturated
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_READ = 8'b0000_0010,
    ST_DIV  = 8'b0000_0100,
    ST_CLIP = 8'b0000_1000,
    ST_DIFF = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_FIN  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } sor3d_state_t;

  // Read order of the stencil points through the old-value port.
  localparam logic [2:0] TAG_C  = 3'd0;
  localparam logic [2:0] TAG_XP = 3'd1;
  localparam logic [2:0] TAG_XM = 3'd2;
  localparam logic [2:0] TAG_YP = 3'd3;
  localparam logic [2:0] TAG_YM = 3'd4;
  localparam logic [2:0] TAG_ZP = 3'd5;
  localparam logic [2:0] TAG_ZM = 3'd6;
  localparam logic [2:0] RD_LAST = 3'd7;
  localparam logic [1:0] DIV_LAST = 2'd3;

  // Quotient digit of a value below 96 divided by six.
  function automatic logic [3:0] div6_q(input logic [6:0] p);
    logic [13:0] m;
    m = 14'(p) * 14'd43;
    return m[11:8];
  endfunction

  function automatic logic [2:0] div6_r(input logic [6:0] p, input logic [3:0] q);
    logic [6:0] r;
    r = p - 7'({3'b000, q}) * 7'd6;
    return r[2:0];
  endfunction

  // Returns {clipped, value} for a 40-bit signed value clipped to 32 bits.
  function automatic logic [32:0] clip32(input logic [39:0] v);
    logic sat;
    sat = (v[39:31] != {9{v[31]}});
    if (sat) begin
      return {1'b1, (v[39] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end
    return {1'b0, v[31:0]};
  endfunction

  sor3d_state_t        state_r, state_nxt;
  sor3d_op_t           kind_r, kind_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [2:0]          rd_cnt_r, rd_cnt_nxt;
  logic [1:0]          div_cnt_r, div_cnt_nxt;
  logic [DATA_W-1:0]   center_r, center_nxt;
  logic [35:0]         sum_r, sum_nxt;
  logic [35:0]         mag_r, mag_nxt;
  logic [35:0]         quo_r, quo_nxt;
  logic [2:0]          rem_r, rem_nxt;
  logic                neg_r, neg_nxt;
  logic [DATA_W-1:0]   t_r, t_nxt;
  logic signed [32:0]  d_r, d_nxt;
  logic signed [48:0]  prod_r, prod_nxt;
  logic [DATA_W-1:0]   res_r, res_nxt;
  logic                wr_r, wr_nxt;
  logic                sat_r, sat_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_new_value_r, out_new_value_nxt;
  logic                out_written_r, out_written_nxt;
  logic                out_saturated_r, out_saturated_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, rd_addr, src_addr;
  logic [DATA_W-1:0]   old_rdata, src_rdata;
  logic [COORD_W-1:0]  xa, ya, za;

  logic [6:0]          p0, p1, p2;
  logic [3:0]          q0, q1, q2;
  logic [2:0]          r0, r1, r2;
  logic [36:0]         qext, tfull;
  logic [32:0]         clip_t, clip_v;
  logic [34:0]         p_s;
  logic [35:0]         v36;
  logic signed [15:0]  om_s;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_we    = q_pop && (q_entry.op == OP_LOAD);
  assign ram_waddr = {q_entry.z, q_entry.y, q_entry.x};

  sor3d_ram #(
    .WIDTH(DATA_W),
    .DEPTH(GRID_DEPTH)
  ) u_old_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_entry.old_value),
    .raddr (rd_addr),
    .rdata (old_rdata)
  );

  sor3d_ram #(
    .WIDTH(DATA_W),
    .DEPTH(GRID_DEPTH)
  ) u_src_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_entry.source),
    .raddr (src_addr),
    .rdata (src_rdata)
  );

  // Neighbor coordinates wrap within the 4-bit range.
  always_comb begin
    xa = x_r;
    ya = y_r;
    za = z_r;
    unique case (rd_cnt_r)
      TAG_XP:  xa = x_r + COORD_W'(1);
      TAG_XM:  xa = x_r - COORD_W'(1);
      TAG_YP:  ya = y_r + COORD_W'(1);
      TAG_YM:  ya = y_r - COORD_W'(1);
      TAG_ZP:  za = z_r + COORD_W'(1);
      TAG_ZM:  za = z_r - COORD_W'(1);
      default: ;
    endcase
    rd_addr  = {za, ya, xa};
    src_addr = {z_r, y_r, x_r};
  end

  // Three radix-16 long-division digits per cycle.
  always_comb begin
    p0 = {rem_r, mag_r[35:32]};
    q0 = div6_q(p0);
    r0 = div6_r(p0, q0);
    p1 = {r0, mag_r[31:28]};
    q1 = div6_q(p1);
    r1 = div6_r(p1, q1);
    p2 = {r1, mag_r[27:24]};
    q2 = div6_q(p2);
    r2 = div6_r(p2, q2);
  end

  always_comb begin
    qext   = {1'b0, quo_r};
    tfull  = neg_r ? (~qext + 37'd1) : qext;
    clip_t = clip32({{3{tfull[36]}}, tfull});
    om_s   = signed'({1'b0, relax_factor});
    // Arithmetic shift of the product floors toward minus infinity.
    p_s    = prod_r[48:14];
    v36    = {{4{center_r[31]}}, center_r} + {p_s[34], p_s};
    clip_v = clip32({{4{v36[35]}}, v36});
    prod_nxt = om_s * d_r;
    d_nxt    = signed'({t_r[31], t_r}) - signed'({center_r[31], center_r});
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    rd_cnt_nxt  = rd_cnt_r;
    div_cnt_nxt = div_cnt_r;
    center_nxt  = center_r;
    sum_nxt     = sum_r;
    mag_nxt     = mag_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    neg_nxt     = neg_r;
    t_nxt       = t_r;
    res_nxt     = res_r;
    wr_nxt      = wr_r;
    sat_nxt     = sat_r;

    out_valid_nxt     = out_valid_r && !out_ready;
    out_new_value_nxt = out_new_value_r;
    out_written_nxt   = out_written_r;
    out_saturated_nxt = out_saturated_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          kind_nxt   = q_entry.op;
          x_nxt      = q_entry.x;
          y_nxt      = q_entry.y;
          z_nxt      = q_entry.z;
          rd_cnt_nxt = '0;
          res_nxt    = '0;
          wr_nxt     = 1'b0;
          sat_nxt    = 1'b0;
          if (q_entry.op == OP_COPY || q_entry.op == OP_STENCIL) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        // Data of the address issued in the previous cycle arrives now.
        if (rd_cnt_r != '0) begin
          if (rd_cnt_r - 3'd1 == TAG_C) begin
            center_nxt = old_rdata;
            sum_nxt    = ~{{3{src_rdata[31]}}, src_rdata, 1'b0} + 36'd1;
          end else begin
            sum_nxt = sum_r + {{4{old_rdata[31]}}, old_rdata};
          end
        end
        if (kind_r == OP_COPY && rd_cnt_r == 3'd1) begin
          res_nxt   = old_rdata;
          wr_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else if (rd_cnt_r == RD_LAST) begin
          div_cnt_nxt = '0;
          state_nxt   = ST_DIV;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 3'd1;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          neg_nxt = sum_r[35];
          mag_nxt = sum_r[35] ? (~sum_r + 36'd1) : sum_r;
          quo_nxt = '0;
          rem_nxt = '0;
        end else begin
          mag_nxt = {mag_r[23:0], 12'd0};
          quo_nxt = {quo_r[23:0], q0, q1, q2};
          rem_nxt = r2;
        end
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_CLIP;
        end else begin
          div_cnt_nxt = div_cnt_r + 2'd1;
        end
      end
      ST_CLIP: begin
        t_nxt     = clip_t[31:0];
        sat_nxt   = clip_t[32];
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        res_nxt   = clip_v[31:0];
        sat_nxt   = sat_r | clip_v[32];
        wr_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_new_value_nxt = res_r;
          out_written_nxt   = wr_r;
          out_saturated_nxt = sat_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r          <= kind_nxt;
    x_r             <= x_nxt;
    y_r             <= y_nxt;
    z_r             <= z_nxt;
    center_r        <= center_nxt;
    sum_r           <= sum_nxt;
    mag_r           <= mag_nxt;
    quo_r           <= quo_nxt;
    rem_r           <= rem_nxt;
    neg_r           <= neg_nxt;
    t_r             <= t_nxt;
    d_r             <= (state_r == ST_DIFF) ? d_nxt : d_r;
    prod_r          <= (state_r == ST_MUL) ? prod_nxt : prod_r;
    res_r           <= res_nxt;
    wr_r            <= wr_nxt;
    sat_r           <= sat_nxt;
    out_new_value_r <= out_new_value_nxt;
    out_written_r   <= out_written_nxt;
    out_saturated_r <= out_saturated_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = signed'(out_new_value_r);
  assign out_written   = out_written_r;
  assign out_saturated = out_saturated_r;

endmodule

// ===== rtl/sor_stencil_3d.sv =====
// ----------------------------------------------------------------------------
// SOR 3D stencil
// Point-wise successive over-relaxation on a 7-point stencil over a haloed
// 3D grid held in on-chip old-value and source memories.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Carries
// in_*      input      in_valid/in_ready    command, x/y/z index, old value, source
// out_*     output     out_valid/out_ready  new value, written, saturated
// cfg_*     input      cfg_valid/cfg_ready  relaxation factor (Q1.14)
//
// The back end handles one request at a time. A load or skipped point needs no
// read, a halo copy one read and an interior point the longest run, set by the
// seven reads through the one read port of the old-value memory and the
// radix-16 division by six. A two-entry queue lets requests arrive while the
// back end is busy, and the result register lets the next request start while
// a result waits. Reset clears control state only; memories are not cleared.
// ----------------------------------------------------------------------------
module sor_stencil_3d import sor3d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [COORD_W-1:0]        in_x_index,
  input  logic [COORD_W-1:0]        in_y_index,
  input  logic [COORD_W-1:0]        in_z_index,
  input  logic signed [DATA_W-1:0]  in_old_value_in,
  input  logic signed [DATA_W-1:0]  in_source_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_new_value,
  output logic                      out_written,
  output logic                      out_saturated,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [RELAX_W-1:0]        cfg_relax_factor
);

  logic [RELAX_W-1:0] relax_factor_r, relax_factor_nxt;
  logic               q_full, q_push, q_valid, q_pop;
  sor3d_entry_t       push_entry, head_entry;

  assign cfg_ready        = 1'b1;
  assign relax_factor_nxt = cfg_valid ? cfg_relax_factor : relax_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_factor_r <= RELAX_RESET;
    end else begin
      relax_factor_r <= relax_factor_nxt;
    end
  end

  sor3d_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_x_index      (in_x_index),
    .in_y_index      (in_y_index),
    .in_z_index      (in_z_index),
    .in_old_value_in (in_old_value_in),
    .in_source_in    (in_source_in),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (push_entry)
  );

  sor3d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  sor3d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .relax_factor  (relax_factor_r),
    .q_valid       (q_valid),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_value (out_new_value),
    .out_written   (out_written),
    .out_saturated (out_saturated)
  );

endmodule

// ===== rtl/sor3d_checker.sv =====
// ----------------------------------------------------------------------------
// SOR stencil checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sor_stencil_3d_defines.svh"

module sor3d_checker import sor3d_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DATA_W-1:0]  out_new_value,
  input logic                      out_written,
  input logic                      out_saturated
);

  // A stalled result keeps its valid and its payload.
  `SOR3D_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_new_value) && $stable(out_written) && $stable(out_saturated)), "result changed while stalled")

  // Loads and skipped points report a zero value and no clipping.
  `SOR3D_ASSERT(a_unwritten_zero, (out_valid && !out_written) |-> (out_new_value == '0 && !out_saturated), "unwritten result is not zero")

  // Clipping is only reported on a computed value.
  `SOR3D_ASSERT(a_sat_written, (out_valid && out_saturated) |-> out_written, "saturated without written")

  // Reset empties the result register.
  `SOR3D_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sor_stencil_3d sor3d_checker u_sor3d_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// SOR stencil regression bench
// Loads old and source values into the grid, then asks for new values at
// halo, interior and skipped points under several relaxation factors. A
// predictor runs at each accepted request. The checker matches every result,
// in order, against the value that the predictor expects.
// ----------------------------------------------------------------------------
module testbench;
  import sor3d_pkg::*;

  localparam int     CYCLE_LIMIT = 500000;
  localparam int     HOLD_CYCLES = 300;
  localparam longint VALUE_MAX   = 64'sd2147483647;
  localparam longint VALUE_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic                     written;
    logic                     saturated;
  } point_update_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_command = CMD_LOAD;
  logic [COORD_W-1:0]       in_x_index = '0;
  logic [COORD_W-1:0]       in_y_index = '0;
  logic [COORD_W-1:0]       in_z_index = '0;
  logic signed [DATA_W-1:0] in_old_value_in = '0;
  logic signed [DATA_W-1:0] in_source_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_new_value;
  logic                     out_written;
  logic                     out_saturated;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [RELAX_W-1:0]       cfg_relax_factor = RELAX_RESET;

  // Shadow copies of the grid stores and the relaxation factor.
  logic signed [DATA_W-1:0] old_mirror [GRID_DEPTH];
  logic signed [DATA_W-1:0] source_mirror [GRID_DEPTH];
  bit                       loaded [GRID_DEPTH];
  logic [RELAX_W-1:0]       relax_mirror = RELAX_RESET;

  point_update_t            awaited_updates [$];
  point_update_t            want;
  int                       mismatch_count = 0;
  int                       items_sent = 0;
  int                       cycle_count = 0;
  int                       hold_left = 0;
  bit                       hold_request = 1'b0;
  bit                       steady_flow = 1'b0;
  logic [COORD_W-1:0]       win_x = 4'd1;
  logic [COORD_W-1:0]       win_y = 4'd1;
  logic [COORD_W-1:0]       win_z = 4'd1;

  sor_stencil_3d i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_x_index       (in_x_index),
    .in_y_index       (in_y_index),
    .in_z_index       (in_z_index),
    .in_old_value_in  (in_old_value_in),
    .in_source_in     (in_source_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_value    (out_new_value),
    .out_written      (out_written),
    .out_saturated    (out_saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_relax_factor (cfg_relax_factor)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sor_stencil_3d regression: fail");
      $finish;
    end
  end

  // What a compute request does at a point; for a copy, from_x is the source x.
  function automatic sor3d_op_t point_kind(input logic [COORD_W-1:0] x, y, z,
                                           output logic [COORD_W-1:0] from_x);
    from_x = x;
    if (x == X_INNER + 1) begin
      from_x = COORD_W'(1);
      return OP_COPY;
    end
    if (x == 0) begin
      from_x = COORD_W'(X_INNER);
      return OP_COPY;
    end
    if (y == Y_INNER + 1) begin
      from_x = x - 1'b1;
      return OP_COPY;
    end
    if (y == 0) return OP_COPY;
    if (x <= X_INNER && y >= 1 && y <= Y_INNER && z >= 1 && z <= Z_INNER)
      return OP_STENCIL;
    return OP_SKIP;
  endfunction

  function automatic int read_count(input logic [COORD_W-1:0] x, y, z);
    logic [COORD_W-1:0] from_x;
    case (point_kind(x, y, z, from_x))
      OP_COPY:    return 1;
      OP_STENCIL: return 7;
      default:    return 0;
    endcase
  endfunction

  // Read k of a compute: the centre or copy source first, then six neighbours.
  function automatic logic [ADDR_W-1:0] read_addr(input logic [COORD_W-1:0] x, y, z,
                                                  input int k);
    logic [COORD_W-1:0] from_x, xp, xm, yp, ym, zp, zm;
    xp = x + 1'b1;
    xm = x - 1'b1;
    yp = y + 1'b1;
    ym = y - 1'b1;
    zp = z + 1'b1;
    zm = z - 1'b1;
    if (point_kind(x, y, z, from_x) == OP_COPY) return {z, y, from_x};
    case (k)
      1:       return {z, y, xp};
      2:       return {z, y, xm};
      3:       return {z, yp, x};
      4:       return {z, ym, x};
      5:       return {zp, y, x};
      6:       return {zm, y, x};
      default: return {z, y, x};
    endcase
  endfunction

  function automatic bit point_covered(input logic [COORD_W-1:0] x, y, z);
    int k;
    for (k = 0; k < read_count(x, y, z); k++)
      if (!loaded[read_addr(x, y, z, k)]) return 1'b0;
    return 1'b1;
  endfunction

  // Expected result of one request; a load updates the shadow stores.
  function automatic point_update_t sor_point_update(input logic cmd,
                                                     input logic [COORD_W-1:0] x, y, z,
                                                     input logic signed [DATA_W-1:0] old_value,
                                                     input logic signed [DATA_W-1:0] source);
    point_update_t      r;
    logic [COORD_W-1:0] from_x;
    logic [ADDR_W-1:0]  centre_addr;
    longint             centre, total, quot, step, sum;
    int                 k;
    r = '0;
    if (cmd == CMD_LOAD) begin
      old_mirror[{z, y, x}] = old_value;
      source_mirror[{z, y, x}] = source;
      loaded[{z, y, x}] = 1'b1;
      return r;
    end
    centre_addr = read_addr(x, y, z, 0);
    case (point_kind(x, y, z, from_x))
      OP_COPY: begin
        r.new_value = old_mirror[centre_addr];
        r.written = 1'b1;
      end
      OP_STENCIL: begin
        centre = old_mirror[centre_addr];
        total = -2 * longint'(source_mirror[centre_addr]);
        for (k = 1; k < 7; k++) total = total + old_mirror[read_addr(x, y, z, k)];
        quot = total / 6;
        if (quot > VALUE_MAX) begin
          quot = VALUE_MAX;
          r.saturated = 1'b1;
        end else if (quot < VALUE_MIN) begin
          quot = VALUE_MIN;
          r.saturated = 1'b1;
        end
        // Arithmetic shift of a signed product rounds toward minus infinity.
        step = (longint'(relax_mirror) * (quot - centre)) >>> 14;
        sum = centre + step;
        if (sum > VALUE_MAX) begin
          sum = VALUE_MAX;
          r.saturated = 1'b1;
        end else if (sum < VALUE_MIN) begin
          sum = VALUE_MIN;
          r.saturated = 1'b1;
        end
        r.new_value = sum[DATA_W-1:0];
        r.written = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(input int flavor);
    case (flavor)
      0:       return $urandom;
      1:       return 32'sh7FFFFFFF - $urandom_range(0, 255);
      2:       return 32'sh80000000 + $urandom_range(0, 255);
      default: return $urandom_range(0, 2097151) - 1048576;
    endcase
  endfunction

  // Valid stays high after acceptance; the next call or drain_results moves it.
  task automatic send_request(input logic cmd, input logic [COORD_W-1:0] x, y, z,
                              input logic signed [DATA_W-1:0] old_value,
                              input logic signed [DATA_W-1:0] source);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < 11) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_x_index <= x;
    in_y_index <= y;
    in_z_index <= z;
    in_old_value_in <= old_value;
    in_source_in <= source;
    do @(posedge clk); while (!in_ready);
    awaited_updates.push_back(sor_point_update(cmd, x, y, z, old_value, source));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_updates.size() != 0);
  endtask

  // Only called while nothing is in flight.
  task automatic write_relax(input logic [RELAX_W-1:0] factor);
    cfg_valid <= 1'b1;
    cfg_relax_factor <= factor;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    relax_mirror = factor;
  endtask

  // Loads every entry a compute at the point will read, plus some reloads.
  task automatic prepare_point(input logic [COORD_W-1:0] x, y, z);
    logic [ADDR_W-1:0] a;
    int                old_flavor, source_flavor, k;
    old_flavor = $urandom_range(0, 3);
    source_flavor = $urandom_range(0, 3);
    for (k = 0; k < read_count(x, y, z); k++) begin
      a = read_addr(x, y, z, k);
      if (!loaded[a] || $urandom_range(0, 2) == 0)
        send_request(CMD_LOAD, a[3:0], a[7:4], a[11:8],
                     pick_value(old_flavor), pick_value(source_flavor));
    end
  endtask

  task automatic pick_point(output logic [COORD_W-1:0] x, y, z);
    int roll;
    roll = $urandom_range(0, 99);
    x = COORD_W'($urandom_range(0, 15));
    y = COORD_W'($urandom_range(0, 15));
    z = COORD_W'($urandom_range(0, 15));
    if (roll < 30) begin
      x = win_x + COORD_W'($urandom_range(0, 3));
      y = win_y + COORD_W'($urandom_range(0, 3));
      z = win_z + COORD_W'($urandom_range(0, 3));
    end else if (roll < 55) begin
      x = COORD_W'($urandom_range(1, X_INNER));
      y = COORD_W'($urandom_range(1, Y_INNER));
      z = COORD_W'($urandom_range(1, Z_INNER));
    end else if (roll < 75) begin
      if ($urandom_range(0, 1)) x = $urandom_range(0, 1) ? 4'd15 : 4'd0;
      else y = $urandom_range(0, 1) ? 4'd15 : 4'd0;
    end else if (roll < 85) begin
      x = COORD_W'($urandom_range(1, X_INNER));
      y = COORD_W'($urandom_range(1, Y_INNER));
      z = $urandom_range(0, 1) ? 4'd15 : 4'd0;
    end
  endtask

  task automatic run_sweep(input int budget);
    logic [COORD_W-1:0] x, y, z;
    int                 start, roll;
    start = items_sent;
    while (items_sent - start < budget) begin
      roll = $urandom_range(0, 99);
      pick_point(x, y, z);
      if (roll < 75) begin
        prepare_point(x, y, z);
        send_request(CMD_COMPUTE, x, y, z, $urandom, $urandom);
      end else if (roll < 90) begin
        send_request(CMD_LOAD, x, y, z, pick_value($urandom_range(0, 3)),
                     pick_value($urandom_range(0, 3)));
      end else if (point_covered(x, y, z)) begin
        send_request(CMD_COMPUTE, x, y, z, $urandom, $urandom);
      end else begin
        send_request(CMD_LOAD, x, y, z, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_halo_copies();
    send_request(CMD_LOAD, 4'd1, 4'd5, 4'd15, 32'sh0001_8000, 32'sh0);
    send_request(CMD_LOAD, 4'd14, 4'd5, 4'd5, -32'sh0002_4000, 32'sh7FFFFFFF);
    send_request(CMD_LOAD, 4'd4, 4'd15, 4'd5, 32'sh7FFFFFFF, 32'sh80000000);
    send_request(CMD_LOAD, 4'd6, 4'd0, 4'd5, 32'sh80000000, -32'sh1);
    send_request(CMD_COMPUTE, 4'd15, 4'd5, 4'd15, $urandom, $urandom);
    send_request(CMD_COMPUTE, 4'd0, 4'd5, 4'd5, $urandom, $urandom);
    send_request(CMD_COMPUTE, 4'd5, 4'd15, 4'd5, $urandom, $urandom);
    send_request(CMD_COMPUTE, 4'd6, 4'd0, 4'd5, $urandom, $urandom);
  endtask

  task automatic test_interior_point();
    logic [ADDR_W-1:0] a;
    int                k;
    for (k = 0; k < 7; k++) begin
      a = read_addr(4'd5, 4'd5, 4'd5, k);
      send_request(CMD_LOAD, a[3:0], a[7:4], a[11:8],
                   (k + 1) * 32'sh0001_0000 + k * 1234, -32'sh0000_8000 * k);
    end
    send_request(CMD_COMPUTE, 4'd5, 4'd5, 4'd5, $urandom, $urandom);
    // An interior x,y on the bottom z layer gives no value.
    send_request(CMD_COMPUTE, 4'd5, 4'd5, 4'd0, $urandom, $urandom);
  endtask

  task automatic test_saturation();
    logic [ADDR_W-1:0] a;
    int                k;
    for (k = 0; k < 7; k++) begin
      a = read_addr(4'd9, 4'd9, 4'd9, k);
      if (k == 0) send_request(CMD_LOAD, a[3:0], a[7:4], a[11:8], 32'sh80000000,
                               32'sh80000000);
      else send_request(CMD_LOAD, a[3:0], a[7:4], a[11:8], 32'sh7FFFFFFF, 32'sh0);
    end
    send_request(CMD_COMPUTE, 4'd9, 4'd9, 4'd9, $urandom, $urandom);
  endtask

  task automatic test_relax_extremes();
    drain_results();
    write_relax(15'h7FFF);
    send_request(CMD_COMPUTE, 4'd9, 4'd9, 4'd9, $urandom, $urandom);
    send_request(CMD_COMPUTE, 4'd5, 4'd5, 4'd5, $urandom, $urandom);
    drain_results();
    write_relax(15'd0);
    send_request(CMD_COMPUTE, 4'd5, 4'd5, 4'd5, $urandom, $urandom);
  endtask

  task automatic test_backpressure();
    drain_results();
    write_relax(RELAX_W'($urandom_range(0, 32767)));
    hold_request = 1'b1;
    run_sweep(24);
    drain_results();
  endtask

  task automatic test_random_sweeps();
    logic [RELAX_W-1:0] factors [6];
    int                 p;
    factors = '{RELAX_RESET, 15'h7FFF, 15'd0, 15'($urandom), 15'd1, 15'($urandom)};
    for (p = 0; p < 6; p++) begin
      drain_results();
      write_relax(factors[p]);
      win_x = COORD_W'($urandom_range(1, 11));
      win_y = COORD_W'($urandom_range(1, 11));
      win_z = COORD_W'($urandom_range(1, 11));
      steady_flow = (p == 3);
      run_sweep(192);
    end
    steady_flow = 1'b0;
  endtask

  // Result side: random stalls, the long hold-off, and the in-order check.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_updates.size() == 0) begin
        $display("%0t: unexpected result, new_value %h written %b saturated %b",
                 $time, out_new_value, out_written, out_saturated);
        mismatch_count++;
      end else begin
        want = awaited_updates.pop_front();
        if (out_new_value !== want.new_value) begin
          $display("%0t: new_value expected %h actual %h", $time, want.new_value,
                   out_new_value);
          mismatch_count++;
        end
        if (out_written !== want.written) begin
          $display("%0t: written expected %b actual %b", $time, want.written, out_written);
          mismatch_count++;
        end
        if (out_saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_saturated);
          mismatch_count++;
        end
      end
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_flow || ($urandom_range(0, 99) >= 11);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_halo_copies();
    test_interior_point();
    test_saturation();
    test_relax_extremes();
    test_backpressure();
    test_random_sweeps();
    drain_results();
    // Leave room for a stray result to show up.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sor_stencil_3d regression: pass");
    end else begin
      $display("sor_stencil_3d regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sor3d_pkg.sv
rtl/sor3d_ram.sv
rtl/sor3d_front.sv
rtl/sor3d_queue.sv
rtl/sor3d_back.sv
rtl/sor_stencil_3d.sv
rtl/sor3d_checker.sv
bench/testbench.sv
